// ===== hw/rtl/cls_pkg.sv =====
// ----------------------------------------------------------------------------
// cls_pkg: shared types for the compacting list store
// Request and response payloads, opcode and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

  // Fixed field widths of the request and response payloads
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  // Operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_SHRINK = 2'd3
  } op_e_t;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic                     found;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic [CNT_W-1:0]         capacity;
  } out_rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SCAN_ISSUE,
    S_SCAN_CHECK,
    S_SHIFT_ISSUE,
    S_SHIFT_WRITE,
    S_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, clear pointer and result
    logic append;     // append value or flag full
    logic shrink;     // set capacity to count when non-empty
    logic rd_idx;     // read entry at request index
    logic set_range;  // flag read index out of range
    logic take_data;  // capture read data into result
    logic rd_ptr;     // read entry at scan pointer
    logic ptr_inc;    // advance scan pointer
    logic hit;        // mark found, drop one entry from count
    logic rd_next;    // read entry just above pointer
    logic wr_shift;   // write read data at pointer, advance pointer
    logic out_load;   // load response register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e_t op;
    logic  idx_ok;
    logic  ptr_end;
    logic  eq_hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cls_datapath.sv =====
// ----------------------------------------------------------------------------
// cls_datapath: entry memory, count, capacity and response register
// Executes the commands of the controller: append with capacity doubling,
// indexed read, search and compaction for remove, and shrink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cls_datapath #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned INIT_CAP = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  cls_pkg::in_req_t in_req,
  input  cls_pkg::cmd_t    cmd,
  output cls_pkg::sts_t    sts,
  output cls_pkg::out_rsp_t out_rsp
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MAXC = (DEPTH > INIT_CAP) ? DEPTH : INIT_CAP;
  localparam int unsigned KW   = $clog2(MAXC + 1);
  localparam int unsigned CMPW = (CW > cls_pkg::IDX_W) ? CW : cls_pkg::IDX_W;

  logic signed [cls_pkg::WORD_W-1:0] mem [DEPTH];

  cls_pkg::op_e_t                    op_r;
  logic signed [cls_pkg::WORD_W-1:0] value_r;
  logic [cls_pkg::IDX_W-1:0]         idx_r;
  logic [CW-1:0]                     count_r;
  logic [KW-1:0]                     cap_r;
  logic [CW-1:0]                     ptr_r;
  logic signed [cls_pkg::WORD_W-1:0] rdata_r;
  logic signed [cls_pkg::WORD_W-1:0] res_data_r;
  logic                              res_found_r;
  logic [1:0]                        res_status_r;
  cls_pkg::out_rsp_t                 out_rsp_r;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic signed [cls_pkg::WORD_W-1:0] wdata;
  logic          wen;
  logic [KW:0]   cnt_w;
  logic [KW:0]   cap_w;
  logic [KW:0]   dbl_w;
  logic          at_cap;
  logic          full;

  // Capacity check for append
  assign cnt_w  = (KW + 1)'(count_r);
  assign cap_w  = (KW + 1)'(cap_r);
  assign dbl_w  = {cap_r, 1'b0};
  assign at_cap = (cnt_w == cap_w);
  assign full   = (cnt_w >= (KW + 1)'(DEPTH)) || (at_cap && (dbl_w > (KW + 1)'(DEPTH)));

  // Status back to the controller
  assign sts.op      = op_r;
  assign sts.idx_ok  = CMPW'(idx_r) < CMPW'(count_r);
  assign sts.ptr_end = (ptr_r >= count_r);
  assign sts.eq_hit  = (rdata_r == value_r);

  // Select read address
  always_comb begin
    raddr = AW'(ptr_r);
    if (cmd.rd_idx) begin
      raddr = AW'(CMPW'(idx_r));
    end else if (cmd.rd_next) begin
      raddr = AW'(ptr_r + CW'(1));
    end
  end

  // Select write port
  always_comb begin
    wen   = 1'b0;
    waddr = AW'(ptr_r);
    wdata = rdata_r;
    if (cmd.append && !full) begin
      wen   = 1'b1;
      waddr = AW'(count_r);
      wdata = value_r;
    end else if (cmd.wr_shift) begin
      wen = 1'b1;
    end
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Request capture, pointer and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= cls_pkg::op_e_t'(in_req.opcode);
      value_r      <= in_req.value;
      idx_r        <= in_req.index;
      ptr_r        <= '0;
      res_data_r   <= '0;
      res_found_r  <= 1'b0;
      res_status_r <= cls_pkg::ST_OK;
    end else begin
      if (cmd.ptr_inc || cmd.wr_shift) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.append && full) begin
        res_status_r <= cls_pkg::ST_FULL;
      end
      if (cmd.set_range) begin
        res_status_r <= cls_pkg::ST_RANGE;
      end
      if (cmd.take_data) begin
        res_data_r <= rdata_r;
      end
      if (cmd.hit) begin
        res_found_r <= 1'b1;
      end
    end
  end

  // Count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= KW'(INIT_CAP);
    end else begin
      if (cmd.append && !full) begin
        count_r <= count_r + CW'(1);
        if (at_cap) begin
          cap_r <= KW'(dbl_w);
        end
      end
      if (cmd.hit) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.shrink && (count_r != '0)) begin
        cap_r <= KW'(count_r);
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rsp_r.read_data   <= res_data_r;
      out_rsp_r.found       <= res_found_r;
      out_rsp_r.status      <= res_status_r;
      out_rsp_r.entry_count <= cls_pkg::CNT_W'(count_r);
      out_rsp_r.capacity    <= cls_pkg::CNT_W'(cap_r);
    end
  end

  assign out_rsp = out_rsp_r;

  a_cnt_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    KW'(count_r) <= cap_r)
    else $error("entry count above capacity");

  a_cnt_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (KW + 1)'(count_r) <= (KW + 1)'(DEPTH))
    else $error("entry count above depth");

  a_hit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not drop exactly one entry");

endmodule

`default_nettype wire

// ===== hw/rtl/cls_ctrl.sv =====
// ----------------------------------------------------------------------------
// cls_ctrl: sequencing state machine
// Takes one request at a time, steps the datapath through the operation and
// hands the response to a single output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cls_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  input  cls_pkg::sts_t sts,
  output cls_pkg::cmd_t cmd
);

  cls_pkg::state_t state_r;
  cls_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != cls_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cls_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = cls_pkg::S_DECODE;
        end
      end
      cls_pkg::S_DECODE: begin
        case (sts.op)
          cls_pkg::OP_REMOVE: state_nxt = cls_pkg::S_SCAN_ISSUE;
          cls_pkg::OP_READ:   state_nxt = sts.idx_ok ? cls_pkg::S_READ_WAIT
                                                     : cls_pkg::S_FINISH;
          default:            state_nxt = cls_pkg::S_FINISH;
        endcase
      end
      cls_pkg::S_READ_WAIT: state_nxt = cls_pkg::S_FINISH;
      cls_pkg::S_SCAN_ISSUE: begin
        state_nxt = sts.ptr_end ? cls_pkg::S_FINISH : cls_pkg::S_SCAN_CHECK;
      end
      cls_pkg::S_SCAN_CHECK: begin
        state_nxt = sts.eq_hit ? cls_pkg::S_SHIFT_ISSUE : cls_pkg::S_SCAN_ISSUE;
      end
      cls_pkg::S_SHIFT_ISSUE: begin
        state_nxt = sts.ptr_end ? cls_pkg::S_FINISH : cls_pkg::S_SHIFT_WRITE;
      end
      cls_pkg::S_SHIFT_WRITE: state_nxt = cls_pkg::S_SHIFT_ISSUE;
      cls_pkg::S_FINISH: begin
        if (slot_free) begin
          state_nxt = cls_pkg::S_IDLE;
        end
      end
      default: state_nxt = cls_pkg::S_IDLE;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd = '0;
    case (state_r)
      cls_pkg::S_IDLE: cmd.load = in_valid;
      cls_pkg::S_DECODE: begin
        case (sts.op)
          cls_pkg::OP_APPEND: cmd.append = 1'b1;
          cls_pkg::OP_SHRINK: cmd.shrink = 1'b1;
          cls_pkg::OP_READ: begin
            cmd.rd_idx    = sts.idx_ok;
            cmd.set_range = !sts.idx_ok;
          end
          default: cmd = '0;
        endcase
      end
      cls_pkg::S_READ_WAIT:   cmd.take_data = 1'b1;
      cls_pkg::S_SCAN_ISSUE:  cmd.rd_ptr    = !sts.ptr_end;
      cls_pkg::S_SCAN_CHECK: begin
        cmd.hit     = sts.eq_hit;
        cmd.ptr_inc = !sts.eq_hit;
      end
      cls_pkg::S_SHIFT_ISSUE: cmd.rd_next  = !sts.ptr_end;
      cls_pkg::S_SHIFT_WRITE: cmd.wr_shift = 1'b1;
      cls_pkg::S_FINISH:      cmd.out_load = slot_free;
      default:                cmd = '0;
    endcase
  end

  // Response valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cls_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == cls_pkg::S_DECODE)
    else $error("accepted request not decoded");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("response overwritten before taken");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cls_pkg::S_FINISH && slot_free) |=> out_valid_r)
    else $error("finished request produced no response");

endmodule

`default_nettype wire

// ===== hw/rtl/compacting_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// compacting_list_store_unit: packed list of signed words with capacity
// Append, remove first match with compaction, indexed read and shrink over
// a single-port-read entry memory, sequenced by a controller state machine.
// ----------------------------------------------------------------------------
// From accept to response valid, append and shrink pass DECODE and FINISH;
// read adds READ_WAIT (skipped when the index is out of range); remove runs
// SCAN_ISSUE/SCAN_CHECK per entry searched and SHIFT_ISSUE/SHIFT_WRITE per
// entry moved down, as the single memory read port sets remove time.
// One request in flight; the next is taken once the response is registered.
// Reset clears count to zero and capacity to INIT_CAP; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module compacting_list_store_unit #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned INIT_CAP = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  cls_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  wire               out_stall,
  output cls_pkg::out_rsp_t out_rsp
);

  cls_pkg::cmd_t cmd;
  cls_pkg::sts_t sts;

  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cls_datapath #(
    .DEPTH    (DEPTH),
    .INIT_CAP (INIT_CAP)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for compacting_list_store_unit
// Drives append, remove, read and shrink requests through the valid/stall
// request channel, keeps a shadow copy of the list, count and capacity to
// predict every response, and compares each response field by field.
// Covers directed corners, both ways of filling the store, long random
// traffic with idle and stall bursts, and a final stretch with neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIST_DEPTH    = 64;
  localparam int unsigned LIST_INIT_CAP = 4;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned MAX_PRINTED   = 100;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  cls_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cls_pkg::out_rsp_t out_rsp;

  // Shadow list state, updated as each request is accepted
  logic signed [cls_pkg::WORD_W-1:0] shadow_words [LIST_DEPTH];
  int unsigned shadow_count = 0;
  int unsigned shadow_cap   = LIST_INIT_CAP;

  cls_pkg::out_rsp_t expected_rsp_q [$];
  int unsigned err_count   = 0;
  int unsigned rsp_seen    = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;
  int unsigned gap_pct     = 10;
  int unsigned stall_pct   = 10;
  int unsigned stall_left  = 0;

  compacting_list_store_unit #(
    .DEPTH    (LIST_DEPTH),
    .INIT_CAP (LIST_INIT_CAP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // An append is refused once count hits DEPTH or doubling would pass it
  function automatic bit list_full();
    return (shadow_count >= LIST_DEPTH) ||
           (shadow_count == shadow_cap && 2 * shadow_cap > LIST_DEPTH);
  endfunction

  // Apply one request to the shadow list and return the response it causes
  function automatic cls_pkg::out_rsp_t predict_list_op(cls_pkg::in_req_t r);
    cls_pkg::out_rsp_t rsp;
    int unsigned       pos;
    rsp        = '0;
    rsp.status = cls_pkg::ST_OK;
    case (r.opcode)
      cls_pkg::OP_APPEND: begin
        if (list_full()) begin
          rsp.status = cls_pkg::ST_FULL;
        end else begin
          if (shadow_count == shadow_cap) shadow_cap = 2 * shadow_cap;
          shadow_words[shadow_count] = r.value;
          shadow_count++;
        end
      end
      cls_pkg::OP_REMOVE: begin
        // find the first match, then close the gap
        pos = 0;
        while (pos < shadow_count && shadow_words[pos] != r.value) pos++;
        if (pos < shadow_count) begin
          rsp.found = 1'b1;
          shadow_count--;
          for (int unsigned k = pos; k < shadow_count; k++)
            shadow_words[k] = shadow_words[k + 1];
        end
      end
      cls_pkg::OP_READ: begin
        if (r.index < shadow_count) rsp.read_data = shadow_words[r.index];
        else rsp.status = cls_pkg::ST_RANGE;
      end
      default: begin
        if (shadow_count > 0) shadow_cap = shadow_count;
      end
    endcase
    rsp.entry_count = cls_pkg::CNT_W'(shadow_count);
    rsp.capacity    = cls_pkg::CNT_W'(shadow_cap);
    return rsp;
  endfunction

  // Mix of extremes, a narrow band that breeds duplicates, and full range
  function automatic logic signed [cls_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("tb_top: mismatch at %0t: %s", $time, msg);
  endtask

  // Send one request: optional idle burst, hold it until accepted, then release
  task automatic send_request(input cls_pkg::op_e_t op,
                              input logic signed [cls_pkg::WORD_W-1:0] word,
                              input logic [cls_pkg::IDX_W-1:0] idx);
    cls_pkg::in_req_t r;
    int unsigned      gap;
    r.opcode = op;
    r.value  = word;
    r.index  = idx;
    if (!quiet && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(13, 1);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_req   = r;
    do @(posedge clk); while (in_stall);
    expected_rsp_q.push_back(predict_list_op(r));
    // drop valid so the taken request is not offered again
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drop valid and hold off until every pending response has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain_to(input int unsigned keep);
    while (shadow_count > keep)
      send_request(cls_pkg::OP_REMOVE, shadow_words[$urandom_range(shadow_count - 1)],
                   cls_pkg::IDX_W'($urandom_range(63)));
  endtask

  // One random request, weighted so the list stays busy but not pinned full
  task automatic send_random_item();
    int unsigned                       pick;
    int unsigned                       n_append;
    logic signed [cls_pkg::WORD_W-1:0] word;
    logic [cls_pkg::IDX_W-1:0]         idx;
    pick     = $urandom_range(99);
    n_append = (shadow_count > 40) ? 25 : 45;
    word     = rand_word();
    idx      = cls_pkg::IDX_W'($urandom_range(63));
    if (pick < n_append) begin
      send_request(cls_pkg::OP_APPEND, word, idx);
    end else if (pick < n_append + 25) begin
      if (shadow_count > 0 && $urandom_range(3) != 0)
        word = shadow_words[$urandom_range(shadow_count - 1)];
      send_request(cls_pkg::OP_REMOVE, word, idx);
    end else if (pick < 92) begin
      if (shadow_count > 0 && $urandom_range(4) != 0)
        idx = cls_pkg::IDX_W'($urandom_range(shadow_count - 1));
      send_request(cls_pkg::OP_READ, word, idx);
    end else begin
      send_request(cls_pkg::OP_SHRINK, word, idx);
    end
  endtask

  task automatic test_directed();
    // empty list: nothing to read, remove or shrink
    send_request(cls_pkg::OP_READ,   32'sd0, 6'd0);
    send_request(cls_pkg::OP_REMOVE, 32'sd5, 6'd63);
    send_request(cls_pkg::OP_SHRINK, 32'sd0, 6'd0);
    // value extremes; the fifth append doubles capacity
    send_request(cls_pkg::OP_APPEND, 32'sh8000_0000, 6'd63);
    send_request(cls_pkg::OP_APPEND, 32'sh7fff_ffff, 6'd0);
    send_request(cls_pkg::OP_APPEND, 32'sd0,         6'd0);
    send_request(cls_pkg::OP_APPEND, -32'sd1,        6'd0);
    send_request(cls_pkg::OP_APPEND, 32'sd7,         6'd0);
    send_request(cls_pkg::OP_APPEND, 32'sd7,         6'd0);
    // reads at both ends, just past the count, and at the top index
    send_request(cls_pkg::OP_READ, 32'sd0, 6'd0);
    send_request(cls_pkg::OP_READ, 32'sd0, 6'd5);
    send_request(cls_pkg::OP_READ, 32'sd0, 6'd6);
    send_request(cls_pkg::OP_READ, 32'sd0, 6'd63);
    // duplicate: only the first copy goes; then a middle entry and a miss
    send_request(cls_pkg::OP_REMOVE, 32'sd7,     6'd0);
    send_request(cls_pkg::OP_READ,   32'sd0,     6'd4);
    send_request(cls_pkg::OP_REMOVE, -32'sd1,    6'd0);
    send_request(cls_pkg::OP_REMOVE, 32'sd12345, 6'd0);
    // shrink to the count, then grow from the shrunk capacity
    send_request(cls_pkg::OP_SHRINK, 32'sd0,  6'd0);
    send_request(cls_pkg::OP_APPEND, 32'sd42, 6'd0);
    send_request(cls_pkg::OP_SHRINK, 32'sd0,  6'd0);
    send_request(cls_pkg::OP_APPEND, 32'sd43, 6'd0);
    send_request(cls_pkg::OP_REMOVE, 32'sh8000_0000, 6'd0);
    send_request(cls_pkg::OP_READ,   32'sd0, 6'd0);
    send_request(cls_pkg::OP_READ,   32'sd0, 6'd3);
  endtask

  task automatic test_full_store();
    // shrink to one entry so capacity doubles its way exactly to DEPTH
    if (shadow_count == 0) send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    drain_to(1);
    send_request(cls_pkg::OP_SHRINK, 32'sd0, 6'd0);
    while (!list_full())
      send_request(cls_pkg::OP_APPEND, rand_word(), cls_pkg::IDX_W'($urandom_range(63)));
    send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    send_request(cls_pkg::OP_READ, 32'sd0, 6'd63);
    send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    // from capacity three the next doubling past the count would pass DEPTH
    drain_to(3);
    send_request(cls_pkg::OP_SHRINK, 32'sd0, 6'd0);
    while (!list_full())
      send_request(cls_pkg::OP_APPEND, rand_word(), cls_pkg::IDX_W'($urandom_range(63)));
    send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    send_request(cls_pkg::OP_REMOVE, shadow_words[0], 6'd0);
    send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    send_request(cls_pkg::OP_APPEND, rand_word(), 6'd0);
    send_request(cls_pkg::OP_SHRINK, 32'sd0, 6'd0);
  endtask

  task automatic test_random(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      // hold the sender until the block has answered everything
      if (i % 200 == 199) wait_drained();
      send_random_item();
    end
  endtask

  task automatic test_quiet_tail(input int unsigned n_items);
    wait_drained();
    quiet = 1'b1;
    repeat (n_items) send_random_item();
  endtask

  // Response side: random stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      stall_left = 0;
      out_stall  = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(12);
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic check_response(input cls_pkg::out_rsp_t want);
    rsp_seen++;
    if (out_rsp.read_data !== want.read_data)
      report_mismatch($sformatf("rsp %0d read_data got %0d exp %0d",
                                rsp_seen, out_rsp.read_data, want.read_data));
    if (out_rsp.found !== want.found)
      report_mismatch($sformatf("rsp %0d found got %0b exp %0b",
                                rsp_seen, out_rsp.found, want.found));
    if (out_rsp.status !== want.status)
      report_mismatch($sformatf("rsp %0d status got %0d exp %0d",
                                rsp_seen, out_rsp.status, want.status));
    if (out_rsp.entry_count !== want.entry_count)
      report_mismatch($sformatf("rsp %0d entry_count got %0d exp %0d",
                                rsp_seen, out_rsp.entry_count, want.entry_count));
    if (out_rsp.capacity !== want.capacity)
      report_mismatch($sformatf("rsp %0d capacity got %0d exp %0d",
                                rsp_seen, out_rsp.capacity, want.capacity));
  endtask

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        check_response(expected_rsp_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_full_store();
    test_random(950);
    test_quiet_tail(120);
    wait_drained();
    // catch any stray response after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
